// ----- hdl/imhpq_pkg.sv -----
// Package for the indexed min-heap priority queue: operation and status codes.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package imhpq_pkg;
	localparam logic [1:0] FUNC_INSERT  = 2'd0;
	localparam logic [1:0] FUNC_EXTRACT = 2'd1;
	localparam logic [1:0] FUNC_CHANGE  = 2'd2;
	localparam logic [1:0] FUNC_UNUSED  = 2'd3;

	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_EMPTY   = 3'd1;
	localparam logic [2:0] ST_ABSENT  = 3'd2;
	localparam logic [2:0] ST_FULL    = 3'd3;
	localparam logic [2:0] ST_PRESENT = 3'd4;
endpackage
`default_nettype wire

// ----- hdl/imhpq_ram.sv -----
// Generic single-port RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
module imhpq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] addr,
	input  wire [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule
`default_nettype wire

// ----- hdl/indexed_min_heap_priority_queue_unit.sv -----
// Indexed binary min-heap with decrease/increase key (top level).
// Depends on imhpq_pkg and imhpq_ram.
//
// A rejected item goes straight to the result strobe; an insert sifts up, an
// extract sifts down and a change sifts either way. One item is worked on at
// a time; busy is high meanwhile and drops in the cycle after the strobe.
// The single-port heap and map memories set the pace: every level needs
// sequential reads of parent or children and two writes of each store.
// Reset clears the size, the vertex valid bits and the sequencer; the RAMs
// are not cleared. The result strobe lasts one cycle and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module indexed_min_heap_priority_queue_unit #(
	parameter int CAPACITY     = 256,
	parameter int VERTEX_COUNT = 256,
	parameter int KEY_WIDTH    = 32
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  func,
	input  wire  [7:0]  vertex,
	input  wire  [31:0] distance,
	output logic        done,
	output logic [2:0]  status,
	output logic [7:0]  min_vertex,
	output logic [31:0] min_distance,
	output logic [8:0]  entry_count,
	output logic        heap_empty
);
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int VW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
	localparam int SW = $clog2(CAPACITY + 1);
	localparam int KW = KEY_WIDTH;

	// Sequencer states.
	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_MAPRD  = 5'd1;  // map read issued for change
	localparam logic [4:0] S_MAPWT  = 5'd2;
	localparam logic [4:0] S_OLDRD  = 5'd3;  // old key at the position
	localparam logic [4:0] S_OLDWT  = 5'd4;
	localparam logic [4:0] S_ROOTRD = 5'd5;  // extract: read root
	localparam logic [4:0] S_ROOTWT = 5'd6;
	localparam logic [4:0] S_LASTRD = 5'd7;
	localparam logic [4:0] S_LASTWT = 5'd8;
	localparam logic [4:0] S_CURWR  = 5'd9;  // write current entry at pos
	localparam logic [4:0] S_MAPWR  = 5'd10; // map of current vertex := pos
	localparam logic [4:0] S_UPRD   = 5'd11; // read parent
	localparam logic [4:0] S_UPWT   = 5'd12;
	localparam logic [4:0] S_UPCMP  = 5'd13;
	localparam logic [4:0] S_LRD    = 5'd14; // read left child
	localparam logic [4:0] S_LWT    = 5'd15;
	localparam logic [4:0] S_RRD    = 5'd16;
	localparam logic [4:0] S_RWT    = 5'd17;
	localparam logic [4:0] S_DNCMP  = 5'd18;
	localparam logic [4:0] S_MOVWR  = 5'd19; // write the other entry at pos
	localparam logic [4:0] S_MOVMAP = 5'd20; // and its map
	localparam logic [4:0] S_DONE   = 5'd21;

	logic [4:0]    state_q;
	logic [SW-1:0] size_q;
	logic [VERTEX_COUNT-1:0] valid_q;
	logic          dir_up_q;    // sift direction
	logic [AW-1:0] pos_q;       // current slot of the travelling entry
	logic [AW-1:0] oth_q;       // slot of the parent or chosen child
	logic [VW-1:0] cur_v_q;     // travelling entry
	logic [KW-1:0] cur_k_q;
	logic [VW-1:0] oth_v_q;     // entry being swapped past
	logic [KW-1:0] oth_k_q;
	logic [VW-1:0] lv_q;
	logic [KW-1:0] lk_q;
	logic [2:0]    st_q;
	logic [7:0]    mv_q;
	logic [31:0]   md_q;
	logic          done_q;

	// Memory ports.
	logic          h_we, m_we;
	logic [AW-1:0] h_addr;
	logic [VW-1:0] m_addr;
	logic [VW-1:0] h_wv, h_rv;
	logic [AW-1:0] m_wd, m_rd;
	logic [KW-1:0] h_wk, h_rk;
	logic [VW+KW-1:0] h_rdata;

	imhpq_ram #(.WIDTH(VW + KW), .DEPTH(CAPACITY)) u_heap (
		.clk(clk), .we(h_we), .addr(h_addr), .wdata({h_wv, h_wk}), .rdata(h_rdata)
	);
	assign h_rv = h_rdata[VW+KW-1:KW];
	assign h_rk = h_rdata[KW-1:0];

	imhpq_ram #(.WIDTH(AW), .DEPTH(VERTEX_COUNT)) u_map (
		.clk(clk), .we(m_we), .addr(m_addr), .wdata(m_wd), .rdata(m_rd)
	);

	// Index arithmetic on slots, widened by one bit to catch the end of the heap.
	logic [AW:0] left_w, right_w;
	logic [AW-1:0] parent_w;
	assign left_w   = {pos_q, 1'b1};
	assign right_w  = left_w + 1'b1;
	assign parent_w = AW'((pos_q - 1'b1) >> 1);

	logic [VW-1:0] in_v;
	logic [KW-1:0] in_k;
	logic          v_ok;
	assign in_v = vertex[VW-1:0];
	assign in_k = KW'(64'(distance));
	assign v_ok = (32'(vertex) < VERTEX_COUNT);

	always_comb begin
		h_we = 1'b0;
		m_we = 1'b0;
		h_addr = pos_q;
		m_addr = cur_v_q;
		h_wv = cur_v_q;
		h_wk = cur_k_q;
		m_wd = pos_q;
		unique case (state_q)
			S_MAPRD:  m_addr = cur_v_q;
			S_ROOTRD: h_addr = '0;
			S_LASTRD: h_addr = AW'(size_q - 1'b1);
			S_CURWR:  h_we = 1'b1;
			S_MAPWR:  m_we = 1'b1;
			S_UPRD:   h_addr = parent_w;
			S_UPWT:   h_addr = parent_w;
			S_LRD:    h_addr = left_w[AW-1:0];
			S_RRD:    h_addr = right_w[AW-1:0];
			S_MOVWR: begin
				h_we = 1'b1;
				h_addr = pos_q;
				h_wv = oth_v_q;
				h_wk = oth_k_q;
			end
			S_MOVMAP: begin
				m_we = 1'b1;
				m_addr = oth_v_q;
				m_wd = pos_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			size_q  <= '0;
			valid_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start && !busy) begin
						st_q <= imhpq_pkg::ST_OK;
						mv_q <= '0;
						md_q <= '0;
						cur_v_q <= in_v;
						cur_k_q <= in_k;
						state_q <= S_DONE;
						unique case (func)
							imhpq_pkg::FUNC_INSERT: begin
								if (!v_ok) begin
									st_q <= imhpq_pkg::ST_ABSENT;
								end else if (32'(size_q) >= CAPACITY) begin
									st_q <= imhpq_pkg::ST_FULL;
								end else if (valid_q[in_v]) begin
									st_q <= imhpq_pkg::ST_PRESENT;
								end else begin
									valid_q[in_v] <= 1'b1;
									pos_q <= AW'(size_q);
									size_q <= size_q + 1'b1;
									dir_up_q <= 1'b1;
									state_q <= S_CURWR;
								end
							end
							imhpq_pkg::FUNC_EXTRACT: begin
								if (size_q == '0) begin
									st_q <= imhpq_pkg::ST_EMPTY;
								end else begin
									state_q <= S_ROOTRD;
								end
							end
							imhpq_pkg::FUNC_CHANGE: begin
								if (!v_ok || !valid_q[in_v]) begin
									st_q <= imhpq_pkg::ST_ABSENT;
								end else begin
									state_q <= S_MAPRD;
								end
							end
							default: ;
						endcase
					end
				end
				S_MAPRD: state_q <= S_MAPWT;
				S_MAPWT: begin
					pos_q <= AW'(m_rd);
					if (32'(m_rd) >= 32'(size_q)) begin
						st_q <= imhpq_pkg::ST_ABSENT;
						state_q <= S_DONE;
					end else begin
						state_q <= S_OLDRD;
					end
				end
				S_OLDRD: state_q <= S_OLDWT;
				S_OLDWT: begin
					dir_up_q <= (cur_k_q < h_rk);
					state_q <= S_CURWR;
				end
				S_ROOTRD: state_q <= S_ROOTWT;
				S_ROOTWT: begin
					mv_q <= 8'(h_rv);
					md_q <= 32'(64'(h_rk));
					valid_q[h_rv] <= 1'b0;
					state_q <= S_LASTRD;
				end
				S_LASTRD: state_q <= S_LASTWT;
				S_LASTWT: begin
					size_q <= size_q - 1'b1;
					cur_v_q <= h_rv;
					cur_k_q <= h_rk;
					pos_q <= '0;
					dir_up_q <= 1'b0;
					state_q <= (size_q == SW'(1)) ? S_DONE : S_CURWR;
				end
				S_CURWR: state_q <= S_MAPWR;
				S_MAPWR: begin
					if (dir_up_q) begin
						state_q <= (pos_q == '0) ? S_DONE : S_UPRD;
					end else begin
						state_q <= (32'(left_w) < 32'(size_q)) ? S_LRD : S_DONE;
					end
				end
				S_UPRD: begin
					oth_q <= parent_w;
					state_q <= S_UPWT;
				end
				S_UPWT: state_q <= S_UPCMP;
				S_UPCMP: begin
					oth_v_q <= h_rv;
					oth_k_q <= h_rk;
					state_q <= (cur_k_q < h_rk) ? S_MOVWR : S_DONE;
				end
				S_LRD: state_q <= S_LWT;
				S_LWT: begin
					lv_q <= h_rv;
					lk_q <= h_rk;
					oth_q <= left_w[AW-1:0];
					state_q <= (32'(right_w) < 32'(size_q)) ? S_RRD : S_DNCMP;
				end
				S_RRD: state_q <= S_RWT;
				S_RWT: begin
					// Right child wins only when strictly smaller.
					if (lk_q > h_rk) begin
						lv_q <= h_rv;
						lk_q <= h_rk;
						oth_q <= right_w[AW-1:0];
					end
					state_q <= S_DNCMP;
				end
				S_DNCMP: begin
					oth_v_q <= lv_q;
					oth_k_q <= lk_q;
					state_q <= (lk_q < cur_k_q) ? S_MOVWR : S_DONE;
				end
				S_MOVWR: state_q <= S_MOVMAP;
				S_MOVMAP: begin
					pos_q <= oth_q;
					state_q <= S_CURWR;
				end
				S_DONE: begin
					done_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy         = (state_q != S_IDLE) || done_q;
	assign done         = done_q;
	assign status       = st_q;
	assign min_vertex   = mv_q;
	assign min_distance = md_q;
	assign entry_count  = 9'(size_q);
	assign heap_empty   = (size_q == '0);

	// A memory write only ever happens while an item is in progress.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !(h_we || m_we)) else $error("write while idle");
	// The size never exceeds the capacity.
	a_size_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(size_q) <= CAPACITY) else $error("heap size overflow");
	// The result strobe is one cycle and is followed by idle.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("done held");
	// An accepted item always raises busy in the next cycle.
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("start not taken");
endmodule
`default_nettype wire
